[sv/psus_pkg.sv]
// Shared types, register indexes and reset values for the swing-up sequencer.
package psus_pkg;

	// Widths of the payload fields and registers
	localparam int AngleW  = 16;
	localparam int CmdW    = 2;
	localparam int HalfW   = 15;
	localparam int PushW   = 10;
	localparam int TicksW  = 16;
	localparam int DivW    = 8;
	localparam int DriveW  = 11;
	localparam int WinW    = AngleW + 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;
	localparam int InTdW   = 24;
	localparam int OutTdW  = 24;

	// Register reset values
	localparam logic [AngleW-1:0] CentreAngleRst = 16'd17900;
	localparam logic [HalfW-1:0]  HalfWidthRst   = 15'd3000;
	localparam logic [PushW-1:0]  PushDriveRst   = 10'd35;
	localparam logic [TicksW-1:0] PushTicksRst   = 16'd100;
	localparam logic [DivW-1:0]   JudgeDivRst    = 8'd40;
	localparam logic [DivW-1:0]   InnerDivRst    = 8'd5;
	localparam logic [DivW-1:0]   OuterDivRst    = 8'd50;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_CENTRE_ANGLE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HALF_WIDTH   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PUSH_DRIVE   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PUSH_TICKS   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_JUDGE_DIV    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INNER_DIV    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_OUTER_DIV    = 3'd6;

	// Commands carried with each tick
	localparam logic [CmdW-1:0] CMD_START = 2'd1;
	localparam logic [CmdW-1:0] CMD_STOP  = 2'd2;

	// Run modes
	typedef enum logic [3:0] {
		MODE_STOP       = 4'd0,
		MODE_JUDGE      = 4'd1,
		MODE_LEFT_PUSH  = 4'd2,
		MODE_LEFT_WAIT  = 4'd3,
		MODE_LEFT_PULL  = 4'd4,
		MODE_LEFT_HOLD  = 4'd5,
		MODE_RIGHT_PUSH = 4'd6,
		MODE_RIGHT_WAIT = 4'd7,
		MODE_RIGHT_PULL = 4'd8,
		MODE_RIGHT_HOLD = 4'd9,
		MODE_BALANCE    = 4'd10
	} mode_t;

	// Configuration register set
	typedef struct packed {
		logic [AngleW-1:0] centre_angle;
		logic [HalfW-1:0]  centre_half_width;
		logic [PushW-1:0]  push_drive;
		logic [TicksW-1:0] push_ticks;
		logic [DivW-1:0]   judge_divide;
		logic [DivW-1:0]   inner_divide;
		logic [DivW-1:0]   outer_divide;
	} cfg_t;

	// Window and peak flags for the current tick
	typedef struct packed {
		logic swing_left;
		logic swing_right;
		logic settled;
		logic angle_inside;
	} win_t;

	// One result item
	typedef struct packed {
		logic signed [DriveW-1:0] drive_value;
		logic                     drive_valid;
		mode_t                    mode;
		logic                     pid_reset;
		logic                     inner_update;
		logic                     outer_update;
	} result_t;

endpackage

[sv/psus_window.sv]
// Balance window compare and swing peak detection over the sample history.
module psus_window (
	input  psus_pkg::cfg_t                     cfg,
	input  logic [psus_pkg::AngleW-1:0]        angle,
	input  logic [psus_pkg::AngleW-1:0]        hist0,
	input  logic [psus_pkg::AngleW-1:0]        hist1,
	output psus_pkg::win_t                     win
);
	import psus_pkg::*;

	logic signed [WinW-1:0] lo;
	logic signed [WinW-1:0] hi;
	logic signed [WinW-1:0] s0;
	logic signed [WinW-1:0] s1;
	logic signed [WinW-1:0] s2;

	// Window edges, wide enough to never overflow
	assign lo = $signed({2'b00, cfg.centre_angle}) - $signed({3'b000, cfg.centre_half_width});
	assign hi = $signed({2'b00, cfg.centre_angle}) + $signed({3'b000, cfg.centre_half_width});

	// Newest sample first; s2 is the oldest after the shift
	assign s0 = $signed({2'b00, angle});
	assign s1 = $signed({2'b00, hist0});
	assign s2 = $signed({2'b00, hist1});

	// Trough beyond the high edge, peak below the low edge, or two samples settled
	always_comb begin
		win.swing_left   = (s0 > hi) && (s1 > hi) && (s2 > hi) && (s1 < s0) && (s1 < s2);
		win.swing_right  = (s0 < lo) && (s1 < lo) && (s2 < lo) && (s1 > s0) && (s1 > s2);
		win.angle_inside = (s0 > lo) && (s0 < hi);
		win.settled      = win.angle_inside && (s1 > lo) && (s1 < hi);
	end

endmodule

[sv/psus_ctrl.sv]
// Mode sequencer, tick counters and sample history; forms one result per tick.
module psus_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [psus_pkg::AngleW-1:0]  angle,
	input  logic [psus_pkg::CmdW-1:0]    command,
	input  psus_pkg::cfg_t               cfg,
	output psus_pkg::result_t            result
);
	import psus_pkg::*;

	mode_t              mode_q, mode_eff, mode_n;
	logic [DivW-1:0]    judge_cnt_q, judge_cnt_n, judge_inc;
	logic [DivW-1:0]    inner_cnt_q, inner_cnt_n, inner_inc;
	logic [DivW-1:0]    outer_cnt_q, outer_cnt_n, outer_inc;
	logic [TicksW-1:0]  hold_q, hold_n, hold_dec;
	logic [AngleW-1:0]  hist0_q, hist0_n, hist1_q, hist1_n;
	logic signed [DriveW-1:0] push_pos, push_neg;
	win_t               win;

	psus_window u_window (
		.cfg   (cfg),
		.angle (angle),
		.hist0 (hist0_q),
		.hist1 (hist1_q),
		.win   (win)
	);

	assign judge_inc = judge_cnt_q + 1'b1;
	assign inner_inc = inner_cnt_q + 1'b1;
	assign outer_inc = outer_cnt_q + 1'b1;
	assign hold_dec  = hold_q - 1'b1;
	assign push_pos  = $signed({1'b0, cfg.push_drive});
	assign push_neg  = -push_pos;

	// State register: moves only when the tick is handed to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOP;
			judge_cnt_q <= '0;
			inner_cnt_q <= '0;
			outer_cnt_q <= '0;
			hold_q      <= '0;
			hist0_q     <= '0;
			hist1_q     <= '0;
		end else if (advance) begin
			mode_q      <= mode_n;
			judge_cnt_q <= judge_cnt_n;
			inner_cnt_q <= inner_cnt_n;
			outer_cnt_q <= outer_cnt_n;
			hold_q      <= hold_n;
			hist0_q     <= hist0_n;
			hist1_q     <= hist1_n;
		end
	end

	// Command first, then the tick in the resulting mode
	always_comb begin
		mode_eff = mode_q;
		if (command == CMD_START) begin
			mode_eff = MODE_JUDGE;
		end else if (command == CMD_STOP) begin
			mode_eff = MODE_STOP;
		end

		mode_n      = mode_eff;
		judge_cnt_n = judge_cnt_q;
		inner_cnt_n = inner_cnt_q;
		outer_cnt_n = outer_cnt_q;
		hold_n      = hold_q;
		hist0_n     = hist0_q;
		hist1_n     = hist1_q;

		result.drive_value  = '0;
		result.drive_valid  = 1'b0;
		result.pid_reset    = 1'b0;
		result.inner_update = 1'b0;
		result.outer_update = 1'b0;

		unique case (mode_eff) inside
			MODE_JUDGE: begin
				result.drive_valid = 1'b1;
				judge_cnt_n = judge_inc;
				if (judge_inc >= cfg.judge_divide) begin
					judge_cnt_n = '0;
					hist0_n = angle;
					hist1_n = hist0_q;
					if (win.swing_left) begin
						mode_n = MODE_LEFT_PUSH;
					end else if (win.swing_right) begin
						mode_n = MODE_RIGHT_PUSH;
					end else if (win.settled) begin
						result.pid_reset = 1'b1;
						mode_n = MODE_BALANCE;
					end
				end
			end
			MODE_LEFT_PUSH, MODE_RIGHT_PULL: begin
				result.drive_valid = 1'b1;
				result.drive_value = push_pos;
				hold_n = cfg.push_ticks;
				mode_n = (mode_eff == MODE_LEFT_PUSH) ? MODE_LEFT_WAIT : MODE_RIGHT_HOLD;
			end
			MODE_RIGHT_PUSH, MODE_LEFT_PULL: begin
				result.drive_valid = 1'b1;
				result.drive_value = push_neg;
				hold_n = cfg.push_ticks;
				mode_n = (mode_eff == MODE_RIGHT_PUSH) ? MODE_RIGHT_WAIT : MODE_LEFT_HOLD;
			end
			MODE_LEFT_WAIT, MODE_RIGHT_WAIT: begin
				hold_n = hold_dec;
				if (hold_dec == '0) begin
					mode_n = (mode_eff == MODE_LEFT_WAIT) ? MODE_LEFT_PULL : MODE_RIGHT_PULL;
				end
			end
			MODE_LEFT_HOLD, MODE_RIGHT_HOLD: begin
				hold_n = hold_dec;
				if (hold_dec == '0) begin
					result.drive_valid = 1'b1;
					mode_n = MODE_JUDGE;
				end
			end
			MODE_BALANCE: begin
				inner_cnt_n = inner_inc;
				if (inner_inc >= cfg.inner_divide) begin
					inner_cnt_n = '0;
					if (win.angle_inside) begin
						result.inner_update = 1'b1;
					end else begin
						result.drive_valid = 1'b1;
						result.pid_reset   = 1'b1;
						mode_n = MODE_STOP;
					end
				end
				outer_cnt_n = outer_inc;
				if (outer_inc >= cfg.outer_divide) begin
					outer_cnt_n = '0;
					result.outer_update = 1'b1;
				end
			end
			default: begin
				// stopped, or a code with no meaning
				result.drive_valid = 1'b1;
				mode_n = MODE_STOP;
			end
		endcase

		result.mode = mode_n;
	end

endmodule

[sv/pendulum_swing_up_sequencer.sv]
// Pendulum swing-up sequencer top level: input stage, result stage, registers.
// One request per control tick (angle and command) gives exactly one result
// request. A request is registered on entry, the tick is evaluated in one pass
// of compare-and-count logic and the result is registered on exit; a new
// request is taken every clock while the result side keeps up. Configuration
// registers may be written only while no tick is in flight; they take effect
// on the next tick.
module pendulum_swing_up_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// input requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [psus_pkg::InTdW-1:0]      s_tdata,  // angle_sample[15:0], command[17:16]
	// result requests
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [psus_pkg::OutTdW-1:0]     m_tdata,  // drive_value[10:0], drive_valid[11],
	                                                  // mode[15:12], pid_reset[16],
	                                                  // inner_update[17], outer_update[18]
	// register writes
	input  logic                            cfg_we,
	input  logic [psus_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [psus_pkg::CfgDatW-1:0]    cfg_data
);
	import psus_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1, valid_s2;
	logic [AngleW-1:0]  sample_s1;
	logic [CmdW-1:0]    command_s1;
	logic               advance;
	result_t            result;
	result_t            result_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_angle      <= CentreAngleRst;
			cfg_q.centre_half_width <= HalfWidthRst;
			cfg_q.push_drive        <= PushDriveRst;
			cfg_q.push_ticks        <= PushTicksRst;
			cfg_q.judge_divide      <= JudgeDivRst;
			cfg_q.inner_divide      <= InnerDivRst;
			cfg_q.outer_divide      <= OuterDivRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTRE_ANGLE: cfg_q.centre_angle      <= cfg_data[AngleW-1:0];
				REG_HALF_WIDTH:   cfg_q.centre_half_width <= cfg_data[HalfW-1:0];
				REG_PUSH_DRIVE:   cfg_q.push_drive        <= cfg_data[PushW-1:0];
				REG_PUSH_TICKS:   cfg_q.push_ticks        <= cfg_data[TicksW-1:0];
				REG_JUDGE_DIV:    cfg_q.judge_divide      <= cfg_data[DivW-1:0];
				REG_INNER_DIV:    cfg_q.inner_divide      <= cfg_data[DivW-1:0];
				REG_OUTER_DIV:    cfg_q.outer_divide      <= cfg_data[DivW-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: s1 moves on when the result stage is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1  <= s_tdata[AngleW-1:0];
			command_s1 <= s_tdata[AngleW+CmdW-1:AngleW];
		end
	end

	psus_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.angle   (sample_s1),
		.command (command_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b00000,
	                   result_s2.outer_update,
	                   result_s2.inner_update,
	                   result_s2.pid_reset,
	                   result_s2.mode,
	                   result_s2.drive_valid,
	                   result_s2.drive_value};

`ifndef SYNTHESIS
	// The inner loop sets the drive itself, so this block never does on that tick
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_s2.inner_update && result_s2.drive_valid))
		else $error("inner strobe together with a drive setting");

	// A drive value is only given where the tick sets the drive
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !result_s2.drive_valid) |-> (result_s2.drive_value == '0))
		else $error("drive value without drive setting");

	// A PID reset happens only on entering balance or dropping out of it
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.pid_reset) |->
		(result_s2.mode == MODE_BALANCE || result_s2.mode == MODE_STOP))
		else $error("PID reset outside a balance transition");

	// Loop strobes come only from balance mode or its exit tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (result_s2.inner_update || result_s2.outer_update)) |->
		(result_s2.mode == MODE_BALANCE || result_s2.mode == MODE_STOP))
		else $error("loop strobe outside balance mode");

	// A held result stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> (valid_s2 && $stable(result_s2)))
		else $error("result stage lost a pending request");
`endif

endmodule
